[sv/scl_pkg.sv]
// shared types and constants for the stagger cascade local time block
package scl_pkg;

    localparam int DEFAULT_MAX_UNITS = 1024;

    localparam int IDX_W   = 16;
    localparam int MP_W    = 17;
    localparam int LT_W    = 17;
    localparam int CNT_W   = 11;
    localparam int MS_W    = 24;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [63:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] HASH_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_MUL2   = 64'h94d049bb133111eb;
    localparam logic [31:0] INDEX_MUL   = 32'd2654435761;

    localparam logic [LT_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [MS_W-1:0] MIN_DUR  = 24'd256;

    typedef enum logic [MODE_W-1:0] {
        ORD_START  = 3'd0,
        ORD_END    = 3'd1,
        ORD_CENTER = 3'd2,
        ORD_EDGES  = 3'd3,
        ORD_RANDOM = 3'd4,
        ORD_NONE   = 3'd5
    } order_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTER_MODE  = 3'd0,
        REG_INNER_MODE  = 3'd1,
        REG_OUTER_COUNT = 3'd2,
        REG_INNER_COUNT = 3'd3,
        REG_OUTER_SPACE = 3'd4,
        REG_INNER_SPACE = 3'd5,
        REG_AMOUNT      = 3'd6,
        REG_DURATION    = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_OSPC,
        BK_ISPC,
        BK_ORANK,
        BK_IRANK,
        BK_TOTAL,
        BK_NUM,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // work word handed from front to back
    typedef struct packed {
        logic [MP_W-1:0]  master;
        logic [IDX_W-1:0] oidx;
        logic [IDX_W-1:0] iidx;
    } work_t;

    // settings driven live by the front, with counts, outer mode and duration normalized
    typedef struct packed {
        logic [MODE_W-1:0] omode;
        logic [MODE_W-1:0] imode;
        logic              inner_on;
        logic [IDX_W:0]    ocount;
        logic [IDX_W:0]    icount;
        logic [MS_W-1:0]   ospace;
        logic [MS_W-1:0]   ispace;
        logic              oamt;
        logic              iamt;
        logic [MS_W-1:0]   dur;
    } cfg_t;

    function automatic logic [63:0] sm_hash(input logic [63:0] zi);
        logic [63:0] z;
        z = zi + HASH_GOLDEN;
        z = (z ^ (z >> 30)) * HASH_MUL1;
        z = (z ^ (z >> 27)) * HASH_MUL2;
        return z ^ (z >> 31);
    endfunction

endpackage

[sv/stagger_cascade_local_time_top.sv]
// top level of the stagger cascade local time block
//  channel  | handshake          | payload
//  command  | start / busy       | master_progress, outer_index, inner_index
//  result   | strobe (no stall)  | local_time
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
// one item at a time; the spacing divides (the inner one only with an inner
// cascade), the hash scan of each random level and the serial divide run in
// turn, and the strobe follows the last work state; the spacing divides take
// 24 steps and the serial divide 64 steps; reset clears the registers to
// their documented values and empties the queue; busy stays high from
// acceptance through the strobe
// the receiver cannot stall
module stagger_cascade_local_time_top #(
    parameter int MAX_UNITS = scl_pkg::DEFAULT_MAX_UNITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [scl_pkg::MP_W-1:0]  master_progress,
    input  logic [scl_pkg::IDX_W-1:0] outer_index,
    input  logic [scl_pkg::IDX_W-1:0] inner_index,
    output logic strobe,
    output logic [scl_pkg::LT_W-1:0]  local_time,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [scl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import scl_pkg::*;

    work_t q_in, q_word_reg;
    cfg_t  cfg;
    logic  q_push, q_pop, q_full_reg, busy_back;

    scl_front #(.MAX_UNITS(MAX_UNITS)) u_front (
        .clk, .rst_n, .start(start && !busy),
        .master_progress, .outer_index, .inner_index,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .q_full(q_full_reg), .q_push, .q_word(q_in), .cfg
    );

    // one-entry queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_full_reg <= 1'b0;
        end
        else if (q_push)
        begin
            q_full_reg <= 1'b1;
        end
        else if (q_pop)
        begin
            q_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_word_reg <= q_in;
        end
    end

    scl_back u_back (
        .clk, .rst_n, .q_valid(q_full_reg), .q_pop, .q_word(q_word_reg), .cfg,
        .busy_back, .strobe, .local_time
    );

    assign busy = q_full_reg || busy_back || strobe;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full_reg && !busy_back)
        else $error("command taken while busy");
    a_busy_until_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> busy)
        else $error("busy dropped after accept");
    a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("strobe longer than one cycle");
endmodule

[sv/scl_hash.sv]
// pipelined splitmix64 hash of index*INDEX_MUL + count
module scl_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [15:0] idx,
    input  logic [16:0] count,
    output logic        out_valid,
    output logic [63:0] hash
);
    import scl_pkg::*;

    // partial products over several stages keep each multiply at 32x32
    logic [63:0] z0_reg, z1_reg, z2_reg, a2_reg;
    logic [63:0] p1a_reg, p1b_reg, p1c_reg, p2a_reg, p2b_reg, p2c_reg;
    logic [7:0]  v_reg;
    logic [63:0] x1, x2;

    assign x1 = z0_reg ^ (z0_reg >> 30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        z0_reg  <= {32'd0, 16'd0, idx} * {32'd0, INDEX_MUL} + {47'd0, count} + HASH_GOLDEN;
        p1a_reg <= {32'd0, x1[31:0]} * {32'd0, HASH_MUL1[31:0]};
        p1b_reg <= {32'd0, x1[31:0]} * {32'd0, HASH_MUL1[63:32]};
        p1c_reg <= {32'd0, x1[63:32]} * {32'd0, HASH_MUL1[31:0]};
        z1_reg  <= p1a_reg + {p1b_reg[31:0], 32'd0} + {p1c_reg[31:0], 32'd0};
        a2_reg  <= z1_reg ^ (z1_reg >> 27);
        p2a_reg <= {32'd0, a2_reg[31:0]} * {32'd0, HASH_MUL2[31:0]};
        p2b_reg <= {32'd0, a2_reg[31:0]} * {32'd0, HASH_MUL2[63:32]};
        p2c_reg <= {32'd0, a2_reg[63:32]} * {32'd0, HASH_MUL2[31:0]};
        z2_reg  <= p2a_reg + {p2b_reg[31:0], 32'd0} + {p2c_reg[31:0], 32'd0};
    end

    assign x2 = z2_reg ^ (z2_reg >> 31);
    assign hash = x2;
    // stages: z0, p1, z1, a2, p2, z2; out_valid is delayed to line up with z2
    assign out_valid = v_reg[5];
endmodule

[sv/scl_front.sv]
// front end: takes commands, normalizes settings, pushes work words
module scl_front #(
    parameter int MAX_UNITS = scl_pkg::DEFAULT_MAX_UNITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [scl_pkg::MP_W-1:0]  master_progress,
    input  logic [scl_pkg::IDX_W-1:0] outer_index,
    input  logic [scl_pkg::IDX_W-1:0] inner_index,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [scl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   q_full,
    output logic                   q_push,
    output scl_pkg::work_t         q_word,
    output scl_pkg::cfg_t          cfg
);
    import scl_pkg::*;

    logic [MODE_W-1:0] omode_reg, imode_reg;
    logic [CNT_W-1:0]  ocnt_reg, icnt_reg;
    logic [MS_W-1:0]   ospc_reg, ispc_reg, dur_reg;
    logic [1:0]        amt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omode_reg <= ORD_START;
            imode_reg <= ORD_NONE;
            ocnt_reg  <= 11'd1;
            icnt_reg  <= 11'd1;
            ospc_reg  <= '0;
            ispc_reg  <= '0;
            amt_reg   <= '0;
            dur_reg   <= MIN_DUR;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_OUTER_MODE:  omode_reg <= cfg_data[MODE_W-1:0];
                REG_INNER_MODE:  imode_reg <= cfg_data[MODE_W-1:0];
                REG_OUTER_COUNT: ocnt_reg  <= cfg_data[CNT_W-1:0];
                REG_INNER_COUNT: icnt_reg  <= cfg_data[CNT_W-1:0];
                REG_OUTER_SPACE: ospc_reg  <= cfg_data[MS_W-1:0];
                REG_INNER_SPACE: ispc_reg  <= cfg_data[MS_W-1:0];
                REG_AMOUNT:      amt_reg   <= cfg_data[1:0];
                REG_DURATION:    dur_reg   <= cfg_data[MS_W-1:0];
                default:         amt_reg   <= amt_reg;
            endcase
        end
    end

    function automatic logic [IDX_W:0] norm_cnt(input logic [CNT_W-1:0] c);
        logic [IDX_W:0] r;
        r = {{(IDX_W+1-CNT_W){1'b0}}, c};
        if (r == '0)
        begin
            r = (IDX_W+1)'(1);
        end
        if (r > (IDX_W+1)'(MAX_UNITS))
        begin
            r = (IDX_W+1)'(MAX_UNITS);
        end
        return r;
    endfunction

    always_comb
    begin
        cfg.omode    = (omode_reg > ORD_RANDOM) ? ORD_START : omode_reg;
        cfg.imode    = imode_reg;
        cfg.inner_on = (imode_reg <= ORD_RANDOM);
        cfg.ocount   = norm_cnt(ocnt_reg);
        cfg.icount   = norm_cnt(icnt_reg);
        cfg.ospace   = ospc_reg;
        cfg.ispace   = ispc_reg;
        cfg.oamt     = amt_reg[0];
        cfg.iamt     = amt_reg[1];
        cfg.dur      = (dur_reg < MIN_DUR) ? MIN_DUR : dur_reg;
    end

    assign q_push        = start && !q_full;
    assign q_word.master = master_progress;
    assign q_word.oidx   = outer_index;
    assign q_word.iidx   = inner_index;
endmodule

[sv/scl_back.sv]
// back end: orders, spacings, totals and the final divide
module scl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  scl_pkg::work_t    q_word,
    input  scl_pkg::cfg_t     cfg,
    output logic              busy_back,
    output logic              strobe,
    output logic [scl_pkg::LT_W-1:0] local_time
);
    import scl_pkg::*;

    back_state_t state_reg, state_next;

    work_t          w_reg;
    logic [IDX_W:0] oi_reg, ii_reg;       // clamped indices
    logic [MS_W-1:0] oeach_reg, ieach_reg;
    logic [IDX_W:0] oord_reg, iord_reg;
    logic [63:0]    acc_reg;              // divide numerator
    logic [63:0]    quo_reg;
    logic [6:0]     cnt_reg;              // generic step counter
    logic [63:0]    total_reg, delay_reg;
    logic [LT_W-1:0] lt_reg;
    logic           strobe_reg;

    // rank scan
    logic [IDX_W:0] issue_reg, recv_reg;
    logic [63:0]    mine_reg;
    logic           have_mine_reg;
    logic [IDX_W:0] rank_reg;

    // hash unit
    logic        h_in_valid, h_out_valid;
    logic [15:0] h_idx;
    logic [16:0] h_count;
    logic [63:0] h_out;

    // small restoring divider for spacing: 24 bits / 17 bits
    logic [MS_W-1:0] dq_reg;
    logic [IDX_W:0]  drem_reg;
    logic [4:0]      dstep_reg;

    logic [IDX_W:0] scan_cnt, scan_idx;
    logic           scan_inner;
    logic [IDX_W:0] dist_o, dist_i;

    scl_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h_in_valid),
        .idx       (h_idx),
        .count     (h_count),
        .out_valid (h_out_valid),
        .hash      (h_out)
    );

    assign scan_inner = (state_reg == BK_IRANK);
    assign scan_cnt   = scan_inner ? cfg.icount : cfg.ocount;
    assign scan_idx   = scan_inner ? ii_reg : oi_reg;

    // first hash is own index, then j = 0..count-1; only random levels scan
    always_comb
    begin
        h_in_valid = ((state_reg == BK_ORANK && cfg.omode == ORD_RANDOM) ||
                      (state_reg == BK_IRANK && cfg.imode == ORD_RANDOM)) &&
                     (issue_reg <= scan_cnt);
        h_idx      = (issue_reg == '0) ? scan_idx[15:0] : 16'(issue_reg - 1'b1);
        h_count    = scan_cnt;
    end

    function automatic logic [IDX_W:0] order_of(input logic [MODE_W-1:0] m,
        input logic [IDX_W:0] cnt, input logic [IDX_W:0] i);
        logic [IDX_W:0] last;
        logic [IDX_W+1:0] tw, d;
        last = cnt - 1'b1;
        tw   = {i, 1'b0};
        d    = (tw >= {1'b0, last}) ? tw - {1'b0, last} : {1'b0, last} - tw;
        case (order_t'(m))
            ORD_END:    return last - i;
            ORD_CENTER: return d[IDX_W:0];
            ORD_EDGES:  return last - d[IDX_W:0];
            default:    return i;
        endcase
    endfunction

    assign dist_o = order_of(cfg.omode, cfg.ocount, oi_reg);
    assign dist_i = order_of(cfg.imode, cfg.icount, ii_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (q_valid) state_next = BK_OSPC;
            BK_OSPC:  if (dstep_reg == 5'd25) state_next = cfg.inner_on ? BK_ISPC : BK_ORANK;
            BK_ISPC:  if (dstep_reg == 5'd25) state_next = BK_ORANK;
            BK_ORANK: if (cfg.omode != ORD_RANDOM || recv_reg == scan_cnt + 1'b1)
                          state_next = cfg.inner_on ? BK_IRANK : BK_TOTAL;
            BK_IRANK: if (cfg.imode != ORD_RANDOM || recv_reg == scan_cnt + 1'b1)
                          state_next = BK_TOTAL;
            BK_TOTAL: if (cnt_reg == 7'd3) state_next = BK_NUM;
            BK_NUM:   if (cnt_reg == 7'd3) state_next = BK_DIV;
            BK_DIV:   if (cnt_reg == 7'd65) state_next = BK_DONE;
            BK_DONE:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == BK_IDLE) && q_valid;
        busy_back = (state_reg != BK_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == BK_DONE);
        end
    end

    // multiply helpers: 24x17 and 17x32 products fit 32-bit class multipliers
    logic [63:0] prod_a, prod_b;

    always_ff @(posedge clk)
    begin
        cnt_reg <= (state_next != state_reg) ? 7'd0 : cnt_reg + 7'd1;
        case (state_reg)
            BK_IDLE:
            begin
                w_reg     <= q_word;
                oi_reg    <= ({1'b0, q_word.oidx} > cfg.ocount - 1'b1) ?
                             cfg.ocount - 1'b1 : {1'b0, q_word.oidx};
                ii_reg    <= ({1'b0, q_word.iidx} > cfg.icount - 1'b1) ?
                             cfg.icount - 1'b1 : {1'b0, q_word.iidx};
                dstep_reg <= '0;
                dq_reg    <= cfg.ospace;
                drem_reg  <= '0;
            end
            BK_OSPC, BK_ISPC:
            begin
                if (dstep_reg < 5'd24)
                begin
                    // one quotient bit a step, divisor count-1
                    logic [IDX_W+1:0] t;
                    logic [IDX_W:0] dv;
                    dv = (state_reg == BK_OSPC) ? cfg.ocount - 1'b1 : cfg.icount - 1'b1;
                    t = {drem_reg, dq_reg[MS_W-1]};
                    if (t >= {1'b0, dv})
                    begin
                        drem_reg <= (IDX_W+1)'(t - {1'b0, dv});
                        dq_reg   <= {dq_reg[MS_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= t[IDX_W:0];
                        dq_reg   <= {dq_reg[MS_W-2:0], 1'b0};
                    end
                    dstep_reg <= dstep_reg + 5'd1;
                end
                else if (dstep_reg == 5'd24)
                begin
                    if (state_reg == BK_OSPC)
                        oeach_reg <= (cfg.oamt && cfg.ospace != '0 && cfg.ocount > 1) ?
                                     dq_reg : cfg.ospace;
                    else
                        ieach_reg <= (cfg.iamt && cfg.ispace != '0 && cfg.icount > 1) ?
                                     dq_reg : cfg.ispace;
                    dstep_reg <= dstep_reg + 5'd1;
                end
                else
                begin
                    dstep_reg <= '0;
                    dq_reg    <= cfg.ispace;
                    drem_reg  <= '0;
                end
                issue_reg <= '0;
                recv_reg  <= '0;
                have_mine_reg <= 1'b0;
                rank_reg  <= '0;
            end
            BK_ORANK, BK_IRANK:
            begin
                if (h_in_valid) issue_reg <= issue_reg + 1'b1;
                if (h_out_valid)
                begin
                    recv_reg <= recv_reg + 1'b1;
                    if (!have_mine_reg)
                    begin
                        mine_reg <= h_out;
                        have_mine_reg <= 1'b1;
                    end
                    else if (h_out < mine_reg ||
                             (h_out == mine_reg && (recv_reg - 1'b1) < scan_idx))
                    begin
                        rank_reg <= rank_reg + 1'b1;
                    end
                end
                if (state_next != state_reg)
                begin
                    if (state_reg == BK_ORANK)
                        oord_reg <= (cfg.omode == ORD_RANDOM) ? rank_reg : dist_o;
                    else
                        iord_reg <= (cfg.imode == ORD_RANDOM) ? rank_reg : dist_i;
                    issue_reg <= '0;
                    recv_reg  <= '0;
                    have_mine_reg <= 1'b0;
                    rank_reg  <= '0;
                end
            end
            BK_TOTAL:
            begin
                // 0: outer terms, 1: inner terms, 2: sum
                case (cnt_reg)
                    7'd0:
                    begin
                        prod_a <= {24'd0, oeach_reg} * {47'd0, oord_reg};
                        prod_b <= {24'd0, oeach_reg} * {47'd0, cfg.ocount - 1'b1};
                    end
                    7'd1:
                    begin
                        delay_reg <= prod_a;
                        total_reg <= prod_b + {40'd0, cfg.dur};
                        prod_a <= cfg.inner_on ? {24'd0, ieach_reg} * {47'd0, iord_reg} : '0;
                        prod_b <= cfg.inner_on ?
                                  {24'd0, ieach_reg} * {47'd0, cfg.icount - 1'b1} : '0;
                    end
                    default:
                    begin
                        if (cnt_reg == 7'd2)
                        begin
                            delay_reg <= delay_reg + prod_a;
                            total_reg <= total_reg + prod_b;
                        end
                    end
                endcase
            end
            BK_NUM:
            begin
                // master (17b) times total (<=42b) in two partial products
                case (cnt_reg)
                    7'd0:
                    begin
                        prod_a <= {47'd0, w_reg.master} * {32'd0, total_reg[31:0]};
                        prod_b <= {47'd0, w_reg.master} * {32'd0, total_reg[63:32]};
                    end
                    7'd1:
                        acc_reg <= prod_a + {prod_b[31:0], 32'd0};
                    7'd2:
                    begin
                        if (acc_reg <= {delay_reg[47:0], 16'd0})
                            acc_reg <= '0;
                        else
                            acc_reg <= acc_reg - {delay_reg[47:0], 16'd0};
                        quo_reg <= '0;
                        prod_a  <= '0;
                    end
                    default:
                        quo_reg <= '0;
                endcase
            end
            BK_DIV:
            begin
                // restoring divide, numerator shifted in from acc_reg
                if (cnt_reg < 7'd64)
                begin
                    logic [64:0] t;
                    t = {prod_a, acc_reg[63]};
                    if (t >= {41'd0, cfg.dur})
                    begin
                        prod_a  <= 64'(t - {41'd0, cfg.dur});
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        prod_a  <= t[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    acc_reg <= {acc_reg[62:0], 1'b0};
                end
                else if (cnt_reg == 7'd64)
                begin
                    lt_reg <= (quo_reg > 64'd65536) ? ONE_Q16 : quo_reg[LT_W-1:0];
                end
            end
            default:
                lt_reg <= lt_reg;
        endcase
    end

    assign strobe     = strobe_reg;
    assign local_time = lt_reg;

    a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == BK_DONE))
        else $error("strobe without done");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == BK_IDLE)
        else $error("pop while working");
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> local_time <= ONE_Q16)
        else $error("result above one");
endmodule
